FILE: design/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// types, constants and register codes shared by the tilt to cursor block
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int ANGLE_W    = 16;
    localparam int DIFF_W     = 18;
    localparam int MAG_W      = 15;
    localparam int GAIN_W     = 24;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int FRAC_BITS  = 15;
    localparam int ROUNDED_W  = PROD_W + 1 - FRAC_BITS;
    localparam int AXIS_W     = 16;
    localparam int SMOOTH_SHIFT = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_YAW_CENTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd3;

    localparam logic signed [DIFF_W-1:0] ANGLE_HALF_TURN = 18'sd23040;
    localparam logic signed [DIFF_W-1:0] ANGLE_FULL_TURN = 18'sd46080;

    localparam logic [MAG_W-1:0]  DEAD_BAND_RESET = 15'd192;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 24'd419418;

    localparam logic [PROD_W:0]      ROUND_HALF = (PROD_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic [ROUNDED_W-1:0] POS_LIMIT  = ROUNDED_W'(32767);
    localparam logic [ROUNDED_W-1:0] NEG_LIMIT  = ROUNDED_W'(32768);

    typedef struct packed {
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [AXIS_W-1:0] cursor_x;
        logic signed [AXIS_W-1:0] cursor_y;
    } t_out_item;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_lane_ctl;

    typedef struct packed {
        logic adv;
        logic space;
    } t_merge_ctl;

endpackage

FILE: design/ttc_in_if.sv
// ----------------------------------------------------------------------------
// ttc_in_if
// valid/ready channel carrying one yaw/roll sample per transaction
// ----------------------------------------------------------------------------
interface ttc_in_if;
    import ttc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/ttc_out_if.sv
// ----------------------------------------------------------------------------
// ttc_out_if
// valid/ready channel carrying one cursor result per transaction
// ----------------------------------------------------------------------------
interface ttc_out_if;
    import ttc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/ttc_axis_lane.sv
// ----------------------------------------------------------------------------
// ttc_axis_lane
// one axis: center, wrap, dead band, gain multiply, round and saturate
// ----------------------------------------------------------------------------
module ttc_axis_lane (
    input  logic                                     i_clk,
    input  ttc_pkg::t_lane_ctl                       i_ctl,
    input  logic signed [ttc_pkg::ANGLE_W-1:0]       i_angle,
    input  logic signed [ttc_pkg::ANGLE_W-1:0]       i_center,
    input  logic        [ttc_pkg::MAG_W-1:0]         i_dead_band,
    input  logic        [ttc_pkg::GAIN_W-1:0]        i_gain,
    output logic signed [ttc_pkg::AXIS_W-1:0]        o_mapped
);
    import ttc_pkg::*;

    logic signed [DIFF_W-1:0]    w_diff;
    logic signed [DIFF_W-1:0]    w_wrap;
    logic        [DIFF_W-1:0]    w_abs;
    logic        [MAG_W-1:0]     w_mag;
    logic                        w_neg;
    logic                        w_zero;

    logic        [MAG_W-1:0]     r_mag;
    logic                        r_neg1;
    logic                        r_zero1;

    logic        [PROD_W-1:0]    r_prod;
    logic                        r_neg2;
    logic                        r_zero2;

    logic        [PROD_W:0]      w_sum;
    logic        [ROUNDED_W-1:0] w_r;
    logic        [ROUNDED_W-1:0] w_rneg;
    logic signed [AXIS_W-1:0]    n_mapped;
    logic signed [AXIS_W-1:0]    r_mapped;

    // stage 1: centered difference, wrap, magnitude, dead band
    always_comb begin
        w_diff = DIFF_W'(i_angle) - DIFF_W'(i_center);
        if (w_diff > ANGLE_HALF_TURN) begin
            w_wrap = w_diff - ANGLE_FULL_TURN;
        end else if (w_diff < -ANGLE_HALF_TURN) begin
            w_wrap = w_diff + ANGLE_FULL_TURN;
        end else begin
            w_wrap = w_diff;
        end
        w_neg  = w_wrap[DIFF_W-1];
        w_abs  = w_neg ? DIFF_W'(-w_wrap) : DIFF_W'(w_wrap);
        w_zero = (w_abs[MAG_W-1:0] <= i_dead_band);
        w_mag  = w_abs[MAG_W-1:0] - i_dead_band;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_mag   <= w_mag;
            r_neg1  <= w_neg;
            r_zero1 <= w_zero;
        end
    end

    // stage 2: gain multiply
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_prod  <= PROD_W'(r_mag) * PROD_W'(i_gain);
            r_neg2  <= r_neg1;
            r_zero2 <= r_zero1;
        end
    end

    // stage 3: round half away from zero, saturate
    always_comb begin
        w_sum  = {1'b0, r_prod} + ROUND_HALF;
        w_r    = w_sum[PROD_W:FRAC_BITS];
        w_rneg = ROUNDED_W'(0) - w_r;
        if (r_zero2) begin
            n_mapped = '0;
        end else if (r_neg2) begin
            n_mapped = (w_r > NEG_LIMIT) ? AXIS_W'(16'sh8000) : signed'(w_rneg[AXIS_W-1:0]);
        end else begin
            n_mapped = (w_r > POS_LIMIT) ? AXIS_W'(16'sh7fff) : signed'(w_r[AXIS_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_mapped <= n_mapped;
        end
    end

    assign o_mapped = r_mapped;

endmodule

FILE: design/ttc_smoother.sv
// ----------------------------------------------------------------------------
// ttc_smoother
// merges both lanes: zero clear, first-sample load, shift-by-two smoothing
// ----------------------------------------------------------------------------
module ttc_smoother (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [ttc_pkg::AXIS_W-1:0]    i_mx,
    input  logic signed [ttc_pkg::AXIS_W-1:0]    i_my,
    output ttc_pkg::t_merge_ctl                  o_ctl,
    ttc_out_if.source                            o_out
);
    import ttc_pkg::*;

    logic signed [AXIS_W-1:0] r_sx;
    logic signed [AXIS_W-1:0] r_sy;
    logic signed [AXIS_W-1:0] n_sx;
    logic signed [AXIS_W-1:0] n_sy;
    logic                     r_primed;
    logic                     n_primed;
    logic                     r_ov;
    logic                     w_space;
    logic                     w_adv;
    logic signed [AXIS_W:0]   w_dx;
    logic signed [AXIS_W:0]   w_dy;
    logic signed [AXIS_W:0]   w_sumx;
    logic signed [AXIS_W:0]   w_sumy;

    assign w_space = !r_ov || o_out.ready;
    assign w_adv   = i_valid && w_space;

    always_comb begin
        w_dx   = (AXIS_W+1)'(i_mx) - (AXIS_W+1)'(r_sx);
        w_dy   = (AXIS_W+1)'(i_my) - (AXIS_W+1)'(r_sy);
        w_sumx = (AXIS_W+1)'(r_sx) + (w_dx >>> SMOOTH_SHIFT);
        w_sumy = (AXIS_W+1)'(r_sy) + (w_dy >>> SMOOTH_SHIFT);
        if (i_mx == '0 && i_my == '0) begin
            n_sx     = '0;
            n_sy     = '0;
            n_primed = 1'b0;
        end else if (!r_primed) begin
            n_sx     = i_mx;
            n_sy     = i_my;
            n_primed = 1'b1;
        end else begin
            n_sx     = w_sumx[AXIS_W-1:0];
            n_sy     = w_sumy[AXIS_W-1:0];
            n_primed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx     <= '0;
            r_sy     <= '0;
            r_primed <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (w_space) begin
                r_ov <= i_valid;
            end
            if (w_adv) begin
                r_sx     <= n_sx;
                r_sy     <= n_sy;
                r_primed <= n_primed;
            end
        end
    end

    assign o_ctl.adv          = w_adv;
    assign o_ctl.space        = w_space;
    assign o_out.valid        = r_ov;
    assign o_out.data.cursor_x = r_sx;
    assign o_out.data.cursor_y = r_sy;

    a_unprimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> (r_sx == '0 && r_sy == '0))
        else $error("smoother holds a value while unprimed");

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && i_mx == '0 && i_my == '0) |=> (!r_primed && r_ov))
        else $error("zero sample did not clear smoother");

    a_first_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_primed && (i_mx != '0 || i_my != '0))
            |=> (r_primed && r_sx == $past(i_mx) && r_sy == $past(i_my)))
        else $error("first sample not loaded");

endmodule

FILE: design/tilt_to_cursor_smoothing.sv
// ----------------------------------------------------------------------------
// tilt_to_cursor_smoothing
// maps yaw/roll samples to smoothed 16-bit cursor axes
// path: lane stage 1, stage 2 and stage 3 registers, then the smoother output register
// throughput: one transaction per cycle while the output accepts results
// reset: sync active low; lane data not reset, others to defaults, smoother unprimed
// ----------------------------------------------------------------------------
module tilt_to_cursor_smoothing (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    ttc_in_if.sink                               i_in,
    ttc_out_if.source                            o_out
);
    import ttc_pkg::*;

    logic signed [ANGLE_W-1:0] r_yaw_center;
    logic signed [ANGLE_W-1:0] r_roll_center;
    logic        [MAG_W-1:0]   r_dead_band;
    logic        [GAIN_W-1:0]  r_gain;

    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      w_free1;
    logic                      w_free2;
    logic                      w_free3;
    t_lane_ctl                 w_lane_ctl;
    t_merge_ctl                w_merge_ctl;
    logic signed [AXIS_W-1:0]  w_mx;
    logic signed [AXIS_W-1:0]  w_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_center  <= '0;
            r_roll_center <= '0;
            r_dead_band   <= DEAD_BAND_RESET;
            r_gain        <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_YAW_CENTER:  r_yaw_center  <= signed'(i_cfg_data[ANGLE_W-1:0]);
                CFG_ROLL_CENTER: r_roll_center <= signed'(i_cfg_data[ANGLE_W-1:0]);
                CFG_DEAD_BAND:   r_dead_band   <= i_cfg_data[MAG_W-1:0];
                CFG_GAIN:        r_gain        <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_free3 = !r_v3 || w_merge_ctl.space;
    assign w_free2 = !r_v2 || w_free3;
    assign w_free1 = !r_v1 || w_free2;

    assign w_lane_ctl.ld1 = w_free1;
    assign w_lane_ctl.ld2 = w_free2;
    assign w_lane_ctl.ld3 = w_free3;

    assign i_in.ready = w_free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_free1) begin
                r_v1 <= i_in.valid;
            end
            if (w_free2) begin
                r_v2 <= r_v1;
            end
            if (w_free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    ttc_axis_lane u_lane_yaw (
        .i_clk       (i_clk),
        .i_ctl       (w_lane_ctl),
        .i_angle     (i_in.data.yaw_angle),
        .i_center    (r_yaw_center),
        .i_dead_band (r_dead_band),
        .i_gain      (r_gain),
        .o_mapped    (w_mx)
    );

    ttc_axis_lane u_lane_roll (
        .i_clk       (i_clk),
        .i_ctl       (w_lane_ctl),
        .i_angle     (i_in.data.roll_angle),
        .i_center    (r_roll_center),
        .i_dead_band (r_dead_band),
        .i_gain      (r_gain),
        .o_mapped    (w_my)
    );

    ttc_smoother u_smoother (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_mx    (w_mx),
        .i_my    (w_my),
        .o_ctl   (w_merge_ctl),
        .o_out   (o_out)
    );

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted transaction not captured");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_free2) |=> r_v1)
        else $error("stalled transaction dropped");

    a_merge_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && w_merge_ctl.space) |=> o_out.valid)
        else $error("merged transaction produced no result");

    a_adv_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_merge_ctl.adv |-> r_v3)
        else $error("smoother advanced without a transaction");

endmodule

FILE: verif/tilt_to_cursor_smoothing_tb.sv
// ----------------------------------------------------------------------------
// tilt_to_cursor_smoothing_tb
// self-checking bench for the tilt to cursor mapper and smoother: a table of
// directed samples and register writes, then randomized register settings
// with slow angle walks, dead band probing and full-range noise; every result
// is compared against its table value or an in-bench model of the mapping and the smoother
// ----------------------------------------------------------------------------
module tilt_to_cursor_smoothing_tb;
    import ttc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 80;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        logic signed [15:0]    yaw;
        logic signed [15:0]    roll;
        bit                    typed;
        logic signed [15:0]    want_x;
        logic signed [15:0]    want_y;
    } t_row;

    typedef struct {
        bit        typed;
        t_out_item want;
    } t_hint;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ttc_in_if  in_ch ();
    ttc_out_if out_ch ();

    tilt_to_cursor_smoothing u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // mirror of the register file and smoother
    logic signed [15:0] yaw_ctr   = '0;
    logic signed [15:0] roll_ctr  = '0;
    logic [14:0]        band_reg  = DEAD_BAND_RESET;
    logic [23:0]        gain_reg  = GAIN_RESET;
    int                 sm_x      = 0;
    int                 sm_y      = 0;
    bit                 sm_primed = 1'b0;

    t_out_item cursor_exp_q[$];
    t_hint     cursor_hint_q[$];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;
    int burst_left    = 0;

    t_out_item mon_pred;
    t_out_item mon_want;
    t_hint     mon_hint;

    t_row dir_plan[$] = '{
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd192, -16'sd192, 1'b1, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd23040, 16'sd0, 1'b1, 16'sh7FFF, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, -16'sd23040, -16'sd23040, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd193, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, -16'sd23040, 16'sd0, 1'b1, 16'sh8000, 16'sd0},
        '{ROW_REG,  CFG_GAIN,        24'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd12345, -16'sd23040, 1'b1, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sd0, 16'sd0},
        '{ROW_REG,  CFG_GAIN,        24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG,  CFG_DEAD_BAND,   24'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
        '{ROW_REG,  CFG_DEAD_BAND,   24'hFF7FFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd0, 16'sd0},
        '{ROW_REG,  CFG_YAW_CENTER,  24'hA58000, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG,  CFG_ROLL_CENTER, 24'h5A7FFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG,  CFG_DEAD_BAND,   24'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, -16'sd1, 16'sd1, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG,  CFG_NO_REG,      24'hFFFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_YAW_CENTER,  24'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0}
    };

    // per-axis angle to cursor counts: wrap, dead band, Q9.15 gain, round, saturate
    function automatic logic signed [15:0] tilt_axis(input logic signed [15:0] angle,
                                                     input logic signed [15:0] center);
        int     d;
        longint prod;
        longint r;
        bit     neg;
        d = int'(angle) - int'(center);
        while (d > int'(ANGLE_HALF_TURN)) d -= int'(ANGLE_FULL_TURN);
        while (d < -int'(ANGLE_HALF_TURN)) d += int'(ANGLE_FULL_TURN);
        neg = (d < 0);
        if (neg) d = -d;
        if (d <= int'(band_reg)) return 16'sd0;
        d -= int'(band_reg);
        prod = longint'(d) * longint'(gain_reg);
        r = (prod + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (neg) return (r > 32768) ? 16'sh8000 : 16'(-r);
        return (r > 32767) ? 16'sh7FFF : 16'(r);
    endfunction

    function automatic t_out_item cursor_predict(input t_in_item it);
        int        mx;
        int        my;
        t_out_item o;
        mx = tilt_axis(it.yaw_angle, yaw_ctr);
        my = tilt_axis(it.roll_angle, roll_ctr);
        if (mx == 0 && my == 0) begin
            sm_x = 0;
            sm_y = 0;
            sm_primed = 1'b0;
        end else if (!sm_primed) begin
            sm_x = mx;
            sm_y = my;
            sm_primed = 1'b1;
        end else begin
            sm_x += (mx - sm_x) >>> SMOOTH_SHIFT;
            sm_y += (my - sm_y) >>> SMOOTH_SHIFT;
        end
        o.cursor_x = 16'(sm_x);
        o.cursor_y = 16'(sm_y);
        return o;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] center_value(input int pick);
        logic signed [15:0] c;
        case (pick % 5)
            0: c = -16'sd23040;
            1: c = 16'sd23040;
            2: c = 16'($urandom_range(0, 46080)) - 16'sd23040;
            3: c = 16'($urandom);
            default: c = 16'sd0;
        endcase
        return {8'($urandom), c};
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stalls from a rotating pattern, re-rolled whenever the 6-bit age counter wraps
    logic [31:0] stall_pat  = '0;
    logic [5:0]  stall_age  = '0;
    int          stall_mode = 0;

    always @(negedge i_clk) begin
        if (stall_age == 0) begin
            stall_pat  = $urandom & ~32'h1;
            stall_mode = $urandom_range(0, 3);
        end
        stall_age = stall_age + 1'b1;
        out_ch.ready <= (stall_mode == 0) || !stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                mon_pred = cursor_predict(in_ch.data);
                mon_hint = cursor_hint_q.pop_front();
                cursor_exp_q.push_back(mon_hint.typed ? mon_hint.want : mon_pred);
                items_sent++;
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (cursor_exp_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: x %0d y %0d", $time,
                             out_ch.data.cursor_x, out_ch.data.cursor_y);
                end else begin
                    mon_want = cursor_exp_q.pop_front();
                    if (out_ch.data.cursor_x !== mon_want.cursor_x) begin
                        errors++;
                        $display("%0t cursor_x mismatch: expected %0d, got %0d", $time,
                                 mon_want.cursor_x, out_ch.data.cursor_x);
                    end
                    if (out_ch.data.cursor_y !== mon_want.cursor_y) begin
                        errors++;
                        $display("%0t cursor_y mismatch: expected %0d, got %0d", $time,
                                 mon_want.cursor_y, out_ch.data.cursor_y);
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t watchdog expired with %0d results outstanding", $time,
                 cursor_exp_q.size());
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_hint h;
        h.typed = typed;
        h.want  = want;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        cursor_hint_q.push_back(h);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // bursts of back-to-back transactions separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (cursor_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        case (idx)
            CFG_YAW_CENTER:  yaw_ctr  = v[15:0];
            CFG_ROLL_CENTER: roll_ctr = v[15:0];
            CFG_DEAD_BAND:   band_reg = v[14:0];
            CFG_GAIN:        gain_reg = v[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_item  it;
        t_out_item want;
        int        pick;
        int        kind;
        int        walk_yaw;
        int        walk_roll;
        int        span;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_YAW_CENTER;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples and register extremes
        foreach (dir_plan[i]) begin
            if (dir_plan[i].kind == ROW_REG) begin
                drain_results();
                write_reg(dir_plan[i].idx, dir_plan[i].value);
            end else begin
                pace_sender();
                it.yaw_angle   = dir_plan[i].yaw;
                it.roll_angle  = dir_plan[i].roll;
                want.cursor_x  = dir_plan[i].want_x;
                want.cursor_y  = dir_plan[i].want_y;
                send_item(it, dir_plan[i].typed, want);
            end
        end

        // randomized register settings, extremes first
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            drain_results();
            pick = (phase < 6) ? phase : $urandom_range(0, 29);
            write_reg(CFG_YAW_CENTER, center_value(pick));
            write_reg(CFG_ROLL_CENTER, center_value(pick + 2));
            case (pick % 6)
                0: write_reg(CFG_DEAD_BAND, {9'($urandom), 15'd0});
                1: write_reg(CFG_DEAD_BAND, {9'($urandom), 15'h7FFF});
                2: write_reg(CFG_DEAD_BAND, {9'($urandom), 15'd23040});
                3: write_reg(CFG_DEAD_BAND, {9'($urandom), 15'd192});
                default: write_reg(CFG_DEAD_BAND, {9'($urandom), 15'($urandom_range(0, 2000))});
            endcase
            case ((pick + 3) % 6)
                0: write_reg(CFG_GAIN, 24'd419418);
                1: write_reg(CFG_GAIN, 24'hFFFFFF);
                2: write_reg(CFG_GAIN, 24'd1);
                3: write_reg(CFG_GAIN, 24'd0);
                4: write_reg(CFG_GAIN, 24'($urandom));
                default: write_reg(CFG_GAIN, 24'($urandom_range(0, 1000000)));
            endcase
            write_reg(CFG_NO_REG, 24'($urandom));
            settings_used++;
            walk_yaw  = int'(yaw_ctr);
            walk_roll = int'(roll_ctr);
            span      = int'(band_reg) + 4;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 149) == 0) drain_results();
                pace_sender();
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    walk_yaw  += $urandom_range(0, 600) - 300;
                    walk_roll += $urandom_range(0, 600) - 300;
                    it.yaw_angle  = 16'(walk_yaw);
                    it.roll_angle = 16'(walk_roll);
                end else if (kind < 7) begin
                    // hover around the dead band edges
                    it.yaw_angle  = 16'(int'(yaw_ctr) + $urandom_range(0, 2 * span) - span);
                    it.roll_angle = 16'(int'(roll_ctr) + $urandom_range(0, 2 * span) - span);
                end else if (kind < 9) begin
                    it.yaw_angle  = 16'($urandom_range(0, 46080)) - 16'sd23040;
                    it.roll_angle = 16'($urandom_range(0, 46080)) - 16'sd23040;
                end else begin
                    it.yaw_angle  = 16'($urandom);
                    it.roll_angle = 16'($urandom);
                end
                want = '0;
                send_item(it, 1'b0, want);
            end
        end

        drain_results();
        $display("covered %0d samples over %0d random register settings plus directed extremes",
                 items_sent, settings_used);
        $display("%0d cursor results checked, %0d errors", results_seen, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: tilt_to_cursor_smoothing.f
design/ttc_pkg.sv
design/ttc_in_if.sv
design/ttc_out_if.sv
design/ttc_axis_lane.sv
design/ttc_smoother.sv
design/tilt_to_cursor_smoothing.sv
verif/tilt_to_cursor_smoothing_tb.sv
